>>> src/rdf_pkg.sv
// Shared types and constants for the recent-ID duplicate filter.
package rdf_pkg;

  // Width of one candidate half and of the full identifier on the ports
  localparam int HALF_BITS = 64;
  localparam int FULL_BITS = 128;
  localparam int COUNT_BITS = 4;
  localparam logic [COUNT_BITS-1:0] MAX_ATTEMPTS_RESET = 4'd8;

  // Result status codes
  localparam logic [2:0] ST_ACCEPT   = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_GAVE_UP  = 3'd3;
  localparam logic [2:0] ST_SRC_FAIL = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;

  // Input item
  typedef struct packed {
    logic                 action;
    logic                 source_ok;
    logic [HALF_BITS-1:0] candidate_high;
    logic [HALF_BITS-1:0] candidate_low;
  } req_t;

  // Result item
  typedef struct packed {
    logic [2:0]           status;
    logic [HALF_BITS-1:0] id_high;
    logic [HALF_BITS-1:0] id_low;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
  } sts_t;

endpackage

>>> src/recent_id_duplicate_filter_top.sv
// A result is registered once the item has been captured, the store scanned and the result committed;
// a duplicate ends the scan at its hit, and zero, failed and clear items or an empty store skip it.
// A new item is taken only after the result of the last one is committed; the pace is set
// by the scan of the recent-ID memory through its one read port, an entry a cycle.
// A stalled result holds the commit of the next item, and with it the input.
// Reset: synchronous, empties the store, zeroes the counters, sets max_attempts to 8.
module recent_id_duplicate_filter_top #(
  parameter int RECENT_DEPTH = 64,
  parameter int ID_BITS = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  rdf_pkg::req_t                  req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output rdf_pkg::rsp_t                  rsp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rdf_pkg::COUNT_BITS-1:0] cfg_data
);

  rdf_pkg::cmd_t cmd;
  rdf_pkg::sts_t sts;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  rdf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rdf_datapath #(
    .RECENT_DEPTH (RECENT_DEPTH),
    .ID_BITS      (ID_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

endmodule

>>> src/rdf_ctrl.sv
// Controller state machine: sequences capture, store scan and result commit.
module rdf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  input  rdf_pkg::sts_t sts,
  output rdf_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FINISH
  } state_t;

  state_t state;

  // Decode commands from the current state
  always_comb begin
    cmd.load   = (state == IDLE) && req_valid;
    cmd.scan   = (state == SCAN);
    cmd.commit = (state == FINISH) && (!rsp_valid || !rsp_stall);
  end

  // Take a new item only between items
  assign req_stall = (state != IDLE);

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (req_valid) state <= SCAN;
        end
        SCAN: begin
          if (sts.scan_done) state <= FINISH;
        end
        FINISH: begin
          if (cmd.commit) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // A new result appears only from a commit
  a_rise_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.commit))
    else $error("result valid rose without a commit");

  // A pending result is never overwritten before transfer
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp_valid || !rsp_stall))
    else $error("commit over a stalled result");

  // Capturing an item starts a scan
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == SCAN))
    else $error("load did not start a scan");

endmodule

>>> src/rdf_datapath.sv
// Datapath: candidate register, recent-ID memory, scan compare and counters.
module rdf_datapath #(
  parameter int RECENT_DEPTH = 64,
  parameter int ID_BITS = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rdf_pkg::req_t                       req,
  input  logic                                cfg_valid,
  input  logic [rdf_pkg::COUNT_BITS-1:0]      cfg_data,
  input  rdf_pkg::cmd_t                       cmd,
  output rdf_pkg::sts_t                       sts,
  output rdf_pkg::rsp_t                       rsp
);

  localparam int FB = rdf_pkg::FULL_BITS;
  localparam int HB = rdf_pkg::HALF_BITS;
  localparam int NB = rdf_pkg::COUNT_BITS;
  localparam int CW = $clog2(RECENT_DEPTH + 1);
  localparam int AW = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(RECENT_DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(RECENT_DEPTH - 1);

  logic [ID_BITS-1:0] mem [RECENT_DEPTH];

  logic [ID_BITS-1:0] cand;
  logic               act_q;
  logic               ok_q;
  logic [CW-1:0]      fill_count;
  logic [AW-1:0]      replace_pointer;
  logic [NB-1:0]      attempt_count;
  logic [NB-1:0]      max_attempts;
  logic [CW-1:0]      scan_idx;
  logic [ID_BITS-1:0] rd_data;
  logic               rd_valid;
  logic               hit;

  logic [FB-1:0]      req_wide;
  logic [FB-1:0]      cand_wide;
  logic               is_zero;
  logic               need_scan;
  logic               scan_live;
  logic [NB-1:0]      attempt_inc;
  logic               give_up;
  logic               accept;
  logic [AW-1:0]      wr_slot;
  logic [2:0]         status_next;
  logic [NB-1:0]      attempt_count_next;

  // Mask the candidate to the identifier width
  assign req_wide  = {req.candidate_high, req.candidate_low};
  assign cand_wide = FB'(cand);
  assign is_zero   = (cand == {ID_BITS{1'b0}});
  assign need_scan = !act_q && ok_q && !is_zero;
  assign scan_live = (scan_idx < fill_count);

  assign sts.scan_done = !need_scan || hit || (!scan_live && !rd_valid);

  // Decide the outcome of the held item
  assign attempt_inc = attempt_count + NB'(1);
  assign give_up     = (attempt_inc == '0) || (attempt_inc >= max_attempts);
  assign accept      = need_scan && !hit;
  assign wr_slot     = (fill_count < DEPTH_C) ? fill_count[AW-1:0] : replace_pointer;

  always_comb begin
    status_next        = rdf_pkg::ST_ACCEPT;
    attempt_count_next = '0;
    if (act_q) begin
      status_next = rdf_pkg::ST_CLEARED;
    end else if (!ok_q) begin
      status_next = rdf_pkg::ST_SRC_FAIL;
    end else if (is_zero || hit) begin
      if (give_up) begin
        status_next = rdf_pkg::ST_GAVE_UP;
      end else begin
        status_next        = is_zero ? rdf_pkg::ST_ZERO : rdf_pkg::ST_DUP;
        attempt_count_next = attempt_inc;
      end
    end
  end

  // Read the store one entry a cycle and write the accepted identifier
  always_ff @(posedge clk) begin
    if (cmd.scan && scan_live) begin
      rd_data <= mem[scan_idx[AW-1:0]];
    end
    if (cmd.commit && accept) begin
      mem[wr_slot] <= cand;
    end
  end

  // Capture the item and hold the result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand  <= req_wide[ID_BITS-1:0];
      act_q <= req.action;
      ok_q  <= req.source_ok;
    end
    if (cmd.commit) begin
      rsp.status  <= status_next;
      rsp.id_high <= (status_next == rdf_pkg::ST_ACCEPT) ? cand_wide[FB-1:HB] : '0;
      rsp.id_low  <= (status_next == rdf_pkg::ST_ACCEPT) ? cand_wide[HB-1:0] : '0;
    end
  end

  // Advance the scan and the filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count      <= '0;
      replace_pointer <= '0;
      attempt_count   <= '0;
      max_attempts    <= rdf_pkg::MAX_ATTEMPTS_RESET;
      scan_idx        <= '0;
      rd_valid        <= 1'b0;
      hit             <= 1'b0;
    end else begin
      if (cfg_valid) max_attempts <= cfg_data;
      if (cmd.load) begin
        scan_idx <= '0;
        rd_valid <= 1'b0;
        hit      <= 1'b0;
      end else if (cmd.scan) begin
        rd_valid <= scan_live;
        if (scan_live) scan_idx <= scan_idx + CW'(1);
        if (rd_valid && (rd_data == cand)) hit <= 1'b1;
      end
      if (cmd.commit) begin
        attempt_count <= attempt_count_next;
        if (act_q) begin
          fill_count      <= '0;
          replace_pointer <= '0;
        end else if (accept) begin
          if (fill_count < DEPTH_C) begin
            fill_count <= fill_count + CW'(1);
          end else begin
            replace_pointer <= (replace_pointer == LAST_C) ? '0 : replace_pointer + AW'(1);
          end
        end
      end
    end
  end

  // The fill count never passes the store depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= DEPTH_C)
    else $error("fill count beyond depth");

  // A committed clear empties the store
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && act_q) |=> (fill_count == '0 && attempt_count == '0))
    else $error("clear did not empty the store");

  // The round-robin pointer moves only once the store is full
  a_ptr_when_full: assert property (@(posedge clk) disable iff (rst)
    (replace_pointer != $past(replace_pointer) && !$past(act_q)) |->
      ($past(fill_count) == DEPTH_C))
    else $error("replace pointer moved before store filled");

endmodule
